// ===== rtl/gst_pkg.sv =====
// Package for the gated sine tone generator: widths, register indexes and the
// quarter-wave sine table, which is built at elaboration. No dependencies.
package gst_pkg;

  localparam int QUARTER_TABLE_DEPTH = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int PHASE_W = 32;
  localparam int COUNT_W = 32;
  localparam int GAIN_W = 16;
  localparam int OUT_W = 16;
  localparam int DEPTH_LOG2 = $clog2(QUARTER_TABLE_DEPTH);
  localparam int ADDR_W = DEPTH_LOG2 + 1;
  localparam int IDX_SHIFT = 30 - DEPTH_LOG2;
  localparam int ENTRY_W = SAMPLE_BITS - 1;
  localparam int PROD_W = ENTRY_W + GAIN_W + 1;
  localparam int MAG_W = OUT_W - 1;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(32768);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_DURATION   = 2'd1,
    REG_GAIN       = 2'd2
  } cfg_reg_t;

  typedef logic [ENTRY_W-1:0] sine_tab_t [0:QUARTER_TABLE_DEPTH];

  // Odd Taylor series through x^15 in unsigned Q2.30 with truncating steps.
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    logic [63:0] amp;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    for (int k = 0; k <= QUARTER_TABLE_DEPTH; k++) begin
      x = (HALF_PI_Q30 * 64'(k)) / QUARTER_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      sum = x;
      term = ((x * x2) >> 30) / 6;
      sum = (sum >= term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 20;
      sum = sum + term;
      term = ((term * x2) >> 30) / 42;
      sum = (sum >= term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 72;
      sum = sum + term;
      term = ((term * x2) >> 30) / 110;
      sum = (sum >= term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 156;
      sum = sum + term;
      term = ((term * x2) >> 30) / 210;
      sum = (sum >= term) ? sum - term : 64'd0;
      if (sum > ONE_Q30) begin
        sum = ONE_Q30;
      end
      v = (sum * amp + (64'd1 << 29)) >> 30;
      if (v > amp) begin
        v = amp;
      end
      tab[k] = v[ENTRY_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// ===== rtl/gated_sine_tone_generator.sv =====
// Gated sine tone generator top level: phase accumulator, sine lookup,
// gain scaling and output register. Depends on gst_pkg.
//
// Usage: software writes the tuning word, the tone length and the Q1.15 gain
// through the configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) while no item is in flight; cfg_ready is always high.
// Each item on the tick channel (tick_valid, tick_ready, restart) yields one
// item on the sample channel (sample_valid, sample_ready, sample_out,
// tone_active). A restart clears the phase and the elapsed count before its
// own sample is formed.
// A tick is registered into the first stage and then into the output register,
// and one item is taken every cycle unless the receiver stalls. The first stage
// looks the phase up in the sine table, the second multiplies by the gain and
// rounds into the output register.
// When the receiver stalls, the output register holds its item and the
// stages fill, after which tick_ready falls until the sample is taken.
// Reset clears the configuration registers, phase and elapsed count and empties the stages.
module gated_sine_tone_generator
  import gst_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    tick_valid,
  output logic                    tick_ready,
  input  logic                    restart,
  output logic                    sample_valid,
  input  logic                    sample_ready,
  output logic signed [OUT_W-1:0] sample_out,
  output logic                    tone_active
);

  logic [PHASE_W-1:0] phase_step;
  logic [COUNT_W-1:0] duration_samples;
  logic [GAIN_W-1:0]  volume_gain;
  logic [PHASE_W-1:0] phase_accum;
  logic [COUNT_W-1:0] elapsed_count;

  logic [PHASE_W-1:0]   phase_cur;
  logic [COUNT_W-1:0]   elapsed_cur;
  logic [DEPTH_LOG2-1:0] idx;
  logic [ADDR_W-1:0]    addr;
  logic                 tick_take;
  logic                 s1_adv;

  logic               s1_valid;
  logic               s1_active;
  logic               s1_neg;
  logic [ENTRY_W-1:0] s1_entry;
  logic [GAIN_W-1:0]  s1_gain;

  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  scaled;
  logic [MAG_W-1:0]   mag;
  logic [OUT_W-1:0]   signed_val;

  assign cfg_ready = 1'b1;

  assign s1_adv = !sample_valid || sample_ready;
  assign tick_ready = !s1_valid || s1_adv;
  assign tick_take = tick_valid && tick_ready;

  assign phase_cur = restart ? '0 : phase_accum;
  assign elapsed_cur = restart ? '0 : elapsed_count;
  assign idx = phase_cur[29:IDX_SHIFT];
  assign addr = phase_cur[PHASE_W-2] ? ADDR_W'(QUARTER_TABLE_DEPTH) - ADDR_W'(idx)
                                     : ADDR_W'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      duration_samples <= '0;
      volume_gain <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_STEP: phase_step <= cfg_data[PHASE_W-1:0];
        REG_DURATION:   duration_samples <= cfg_data[COUNT_W-1:0];
        REG_GAIN:       volume_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accum <= '0;
      elapsed_count <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (tick_take) begin
        phase_accum <= phase_cur + phase_step;
        if (elapsed_cur != '1) begin
          elapsed_count <= elapsed_cur + COUNT_W'(1);
        end else begin
          elapsed_count <= elapsed_cur;
        end
      end
      if (tick_take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      s1_active <= elapsed_cur < duration_samples;
      s1_neg <= phase_cur[PHASE_W-1];
      s1_entry <= SINE_TAB[addr];
      s1_gain <= (volume_gain > GAIN_UNITY) ? GAIN_UNITY : volume_gain;
    end
  end

  always_comb begin
    prod = PROD_W'(s1_entry) * PROD_W'(s1_gain);
    scaled = (prod + (PROD_W'(1) << (SAMPLE_BITS - 2))) >> (SAMPLE_BITS - 1);
    if (scaled > PROD_W'({MAG_W{1'b1}})) begin
      mag = '1;
    end else begin
      mag = scaled[MAG_W-1:0];
    end
    if (!s1_active) begin
      signed_val = '0;
    end else if (s1_neg) begin
      signed_val = -{1'b0, mag};
    end else begin
      signed_val = {1'b0, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (s1_adv) begin
      sample_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      sample_out <= signed_val;
      tone_active <= s1_active;
    end
  end

endmodule

// ===== verif/tb_gated_sine_tone_generator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gated_sine_tone_generator: an in-bench predictor of the sine
// oscillator checks every sample under random idling and back-pressure. Depends on gst_pkg.
module tb_gated_sine_tone_generator;
  import gst_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RX_HOLD_CYCLES = 160;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    logic signed [OUT_W-1:0] sample;
    logic                    active;
  } tone_sample_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    tick_valid = 1'b0;
  logic                    tick_ready;
  logic                    restart = 1'b0;
  logic                    sample_valid;
  logic                    sample_ready = 1'b0;
  logic signed [OUT_W-1:0] sample_out;
  logic                    tone_active;

  logic [ENTRY_W-1:0]  quarter_sine [0:QUARTER_TABLE_DEPTH];
  logic [PHASE_W-1:0]  model_phase = '0;
  logic [COUNT_W-1:0]  model_elapsed = '0;
  logic [PHASE_W-1:0]  cur_step = '0;
  logic [COUNT_W-1:0]  cur_duration = '0;
  logic [GAIN_W-1:0]   cur_gain = '0;

  tone_sample_t pending_samples [$];
  int  err_count = 0;
  int  ticks_sent = 0;
  int  samples_checked = 0;
  int  active_seen = 0;
  int  cfg_writes = 0;
  bit  tick_gaps = 1'b0;
  bit  rx_gaps = 1'b0;
  bit  rx_hold_req = 1'b0;

  gated_sine_tone_generator u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .restart      (restart),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_out   (sample_out),
    .tone_active  (tone_active)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void build_quarter_sine();
    logic [63:0] amp;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    for (int k = 0; k <= QUARTER_TABLE_DEPTH; k++) begin
      x = (HALF_PI_Q30 * 64'(k)) / 64'(QUARTER_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      if (sum > ONE_Q30) begin
        sum = ONE_Q30;
      end
      v = (sum * amp + (64'd1 << 29)) >> 30;
      if (v > amp) begin
        v = amp;
      end
      quarter_sine[k] = v[ENTRY_W-1:0];
    end
  endfunction

  function automatic tone_sample_t next_tone_sample(input logic rst_phase);
    tone_sample_t res;
    logic [1:0]         quad;
    logic [63:0]        idx;
    logic [63:0]        m;
    logic [63:0]        mag;
    logic [GAIN_W-1:0]  gain;
    if (rst_phase) begin
      model_phase = '0;
      model_elapsed = '0;
    end
    res.sample = '0;
    res.active = 1'b0;
    if (model_elapsed < cur_duration) begin
      quad = model_phase[31:30];
      idx = (64'(model_phase[29:0]) * 64'(QUARTER_TABLE_DEPTH)) >> 30;
      if (idx > 64'(QUARTER_TABLE_DEPTH)) begin
        idx = 64'(QUARTER_TABLE_DEPTH);
      end
      if (quad[0]) begin
        idx = 64'(QUARTER_TABLE_DEPTH) - idx;
      end
      gain = (cur_gain > GAIN_UNITY) ? GAIN_UNITY : cur_gain;
      m = 64'(quarter_sine[idx]) * 64'(gain);
      mag = (m + (64'd1 << (SAMPLE_BITS - 2))) >> (SAMPLE_BITS - 1);
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      res.sample = quad[1] ? -$signed(OUT_W'(mag)) : $signed(OUT_W'(mag));
      res.active = 1'b1;
    end
    model_phase = model_phase + cur_step;
    if (model_elapsed != '1) begin
      model_elapsed = model_elapsed + COUNT_W'(1);
    end
    return res;
  endfunction

  // Predict on tick acceptance, check on sample acceptance.
  always @(posedge clk) begin
    tone_sample_t exp_s;
    if (!rst) begin
      if (sample_valid && sample_ready) begin
        if (pending_samples.size() == 0) begin
          $error("unexpected sample: sample_out %0d, tone_active %0b", sample_out, tone_active);
          err_count++;
        end else begin
          exp_s = pending_samples.pop_front();
          samples_checked++;
          if (exp_s.active) begin
            active_seen++;
          end
          if (sample_out !== exp_s.sample) begin
            $error("sample_out: expected %0d, actual %0d", exp_s.sample, sample_out);
            err_count++;
          end
          if (tone_active !== exp_s.active) begin
            $error("tone_active: expected %0b, actual %0b", exp_s.active, tone_active);
            err_count++;
          end
        end
      end
      if (tick_valid && tick_ready) begin
        pending_samples.push_back(next_tone_sample(restart));
        ticks_sent++;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        sample_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      if (rx_gaps) begin
        sample_ready <= ($urandom_range(0, 99) >= 23);
      end else begin
        sample_ready <= 1'b1;
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic send_tick(input logic rs);
    int n;
    n = 0;
    if (tick_gaps) begin
      while ($urandom_range(0, 99) < 23) begin
        n++;
      end
    end
    if (n != 0) begin
      tick_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    tick_valid <= 1'b1;
    restart <= rs;
    do @(posedge clk); while (!tick_ready);
  endtask

  task automatic drain();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      REG_PHASE_STEP: cur_step = d;
      REG_DURATION:   cur_duration = d;
      REG_GAIN:       cur_gain = d[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_tone(input logic [31:0] step, input logic [31:0] dur,
                              input logic [31:0] gain_word);
    drain();
    cfg_write(REG_PHASE_STEP, step);
    cfg_write(REG_DURATION, dur);
    cfg_write(REG_GAIN, gain_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_quadrants();
    program_tone(32'h4000_0000, 32'hFFFF_FFFF, 32'd32768);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  task automatic test_table_edges();
    program_tone(32'h3FFF_FFFF, 32'hFFFF_FFFF, 32'd32768);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
  endtask

  task automatic test_gain_limits();
    program_tone(32'h2345_6789, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    program_tone(32'h2345_6789, 32'hFFFF_FFFF, 32'h0000_0000);
    send_tick(1'b0);
  endtask

  // The tone ends after the set number of samples while the phase runs on.
  task automatic test_duration_gate();
    program_tone(32'h1000_0000, 32'd3, 32'd20000);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    program_tone(32'h1000_0000, 32'd0, 32'd20000);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_unused_register();
    drain();
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_write(REG_UNUSED, 32'h0000_0000);
    cfg_valid <= 1'b0;
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_backpressure();
    program_tone(32'h0123_4567, 32'd1000, 32'd30000);
    tick_gaps = 1'b0;
    rx_hold_req = 1'b1;
    send_tick(1'b1);
    repeat (23) send_tick(1'b0);
  endtask

  task automatic test_random_tones(input int phases, input int per_phase);
    logic [31:0] step;
    logic [31:0] dur;
    logic [31:0] gain_word;
    int          restart_pct;
    for (int ph = 0; ph < phases; ph++) begin
      case ($urandom_range(0, 4))
        0:       step = $urandom_range(1, 1 << 24);
        1:       step = 32'hFFFF_FFFF;
        2:       step = 32'h4000_0000;
        default: step = $urandom();
      endcase
      case ($urandom_range(0, 5))
        0:       dur = 32'd0;
        1:       dur = 32'hFFFF_FFFF;
        2, 3:    dur = $urandom_range(1, 60);
        4:       dur = $urandom_range(61, 400);
        default: dur = $urandom();
      endcase
      gain_word = $urandom();
      case ($urandom_range(0, 4))
        0:       gain_word[15:0] = 16'd32768;
        1:       gain_word[15:0] = 16'($urandom_range(32769, 65535));
        2:       gain_word[15:0] = 16'd0;
        default: gain_word[15:0] = 16'($urandom_range(1, 32767));
      endcase
      if (ph == 0) begin
        step = 32'hFFFF_FFFF;
        dur = 32'hFFFF_FFFF;
        gain_word = 32'd32768;
      end
      program_tone(step, dur, gain_word);
      tick_gaps = (ph != 2);
      rx_gaps = (ph != 2);
      restart_pct = $urandom_range(1, 15);
      for (int i = 0; i < per_phase; i++) begin
        send_tick(i == 0 || $urandom_range(0, 99) < restart_pct);
      end
    end
  endtask

  initial begin
    build_quarter_sine();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    tick_gaps = 1'b1;
    rx_gaps = 1'b1;
    test_reset_defaults();
    test_quadrants();
    test_table_edges();
    test_gain_limits();
    test_duration_gate();
    test_unused_register();
    test_backpressure();
    tick_gaps = 1'b1;
    test_random_tones(8, 100);
    drain();
    $display("Ran %0d ticks and checked %0d samples, %0d of them while the tone sounded.",
             ticks_sent, samples_checked, active_seen);
    $display("Made %0d register writes across extreme and random tone settings.", cfg_writes);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
